>>> sv/pts_pkg.sv
// Shared types and constants for the priority task scheduler.
package pts_pkg;

    localparam int SLOT_W  = 3;
    localparam int PRIO_W  = 4;
    localparam int DELAY_W = 17;

    typedef enum logic [2:0] {
        CMD_CREATE = 3'd0,
        CMD_START  = 3'd1,
        CMD_TICK   = 3'd2,
        CMD_DELAY  = 3'd3,
        CMD_TERM   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_READY = 2'd0,
        ST_DELAY = 2'd1,
        ST_RUN   = 2'd2,
        ST_TERM  = 2'd3
    } status_t;

    // Operation applied to every cell in one sweep pass.
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_SCAN   = 3'd1,
        OP_INSERT = 3'd2,
        OP_TICK   = 3'd3,
        OP_PICK   = 3'd4,
        OP_SETRUN = 3'd5
    } op_t;

    typedef struct packed {
        logic [2:0]          cmd;
        logic [PRIO_W-1:0]   prio_level;
        logic [15:0]         delay_ticks;
    } in_item_t;

    typedef struct packed {
        logic                create_ok;
        logic [SLOT_W-1:0]   new_task;
        logic                running_valid;
        logic [SLOT_W-1:0]   running_task;
        logic                switched;
        logic                start_fresh;
    } out_item_t;

    // Beat passed along the chain from cell to cell.
    typedef struct packed {
        logic                active;
        op_t                 op;
        logic [5:0]          idx;
        logic [PRIO_W-1:0]   prio;
        logic [7:0]          pos;
        logic [PRIO_W-1:0]   lowest;
        logic                found;
        logic [7:0]          best_rank;
        logic [5:0]          best_idx;
        logic [5:0]          tgt;
        logic [1:0]          tgt_status;
        logic [DELAY_W-1:0]  tgt_delay;
        logic                fresh;
    } link_t;

endpackage

>>> sv/pts_cell.sv
// One task slot cell: holds the slot fields and acts on the beat passing by.
module pts_cell
    import pts_pkg::*;
#(
    parameter int IDX_W = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [IDX_W-1:0]  my_idx,
    input  logic [IDX_W:0]    count,
    input  link_t             link_in,
    output link_t             link_out
);

    logic [PRIO_W-1:0]    prio_reg;
    logic [1:0]           status_reg;
    logic [DELAY_W-1:0]   delay_reg;
    logic                 first_reg;
    logic [IDX_W-1:0]     rank_reg;
    link_t                link_reg;
    logic                 link_out_active_reg;

    logic                 filled;
    logic                 is_me;
    link_t                link_next;
    logic [PRIO_W-1:0]    prio_next;
    logic [1:0]           status_next;
    logic [DELAY_W-1:0]   delay_next;
    logic                 first_next;
    logic [IDX_W-1:0]     rank_next;

    assign filled = {1'b0, my_idx} < count;
    assign is_me  = link_in.tgt[IDX_W-1:0] == my_idx && link_in.tgt[5:IDX_W] == '0;

    // Apply the pass operation to this slot and update the beat
    always_comb
    begin
        link_next   = link_in;
        prio_next   = prio_reg;
        status_next = status_reg;
        delay_next  = delay_reg;
        first_next  = first_reg;
        rank_next   = rank_reg;
        if (link_in.active)
        begin
            case (link_in.op)
                OP_SCAN:
                begin
                    if (filled)
                    begin
                        if (prio_reg < link_in.lowest)
                            link_next.lowest = prio_reg;
                        if (prio_reg <= link_in.prio)
                            link_next.pos = link_in.pos + 8'd1;
                    end
                end
                OP_INSERT:
                begin
                    if (filled && 8'(rank_reg) >= link_in.pos)
                        rank_next = rank_reg + 1'b1;
                    if (is_me)
                    begin
                        prio_next   = link_in.prio;
                        status_next = ST_READY;
                        delay_next  = '0;
                        first_next  = 1'b1;
                        rank_next   = link_in.pos[IDX_W-1:0];
                    end
                end
                OP_TICK:
                begin
                    if (filled && status_reg == ST_DELAY)
                    begin
                        if (delay_reg <= DELAY_W'(1))
                        begin
                            delay_next  = '0;
                            status_next = ST_READY;
                        end
                        else
                            delay_next = delay_reg - 1'b1;
                    end
                    if (filled && is_me && link_in.fresh && status_reg == ST_RUN)
                        status_next = ST_READY;
                end
                OP_PICK:
                begin
                    if (filled && status_reg == ST_READY &&
                        (!link_in.found || 8'(rank_reg) > link_in.best_rank))
                    begin
                        link_next.found     = 1'b1;
                        link_next.best_rank = 8'(rank_reg);
                        link_next.best_idx  = 6'(my_idx);
                    end
                end
                OP_SETRUN:
                begin
                    if (is_me)
                    begin
                        status_next = link_in.tgt_status;
                        if (link_in.tgt_status == ST_DELAY)
                            delay_next = link_in.tgt_delay;
                        if (link_in.tgt_status == ST_RUN)
                        begin
                            link_next.fresh = first_reg;
                            first_next      = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Hold slot payload
    always_ff @(posedge clk)
    begin
        prio_reg   <= prio_next;
        status_reg <= status_next;
        delay_reg  <= delay_next;
        first_reg  <= first_next;
        rank_reg   <= rank_next;
        link_reg   <= link_next;
    end

    // Pass beat valid to the neighbor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            link_out_active_reg <= 1'b0;
        else
            link_out_active_reg <= link_next.active;
    end

    always_comb
    begin
        link_out        = link_reg;
        link_out.active = link_out_active_reg;
    end

endmodule

>>> sv/priority_task_scheduler.sv
// Top level: command sequencer, config register and the chain of slot cells.
//
//  channel | handshake              | payload
//  cmd     | start / busy           | cmd_in (in_item_t)
//  result  | done strobe, no stall  | result (out_item_t)
//  config  | APB write/read         | idle_priority at address 0
//
// Each command takes up to three passes down the chain of MAX_TASKS cells:
// a create or start scans then inserts, a tick counts down then picks then
// marks the chosen slot if there is one, a delay or terminate takes one pass,
// and a command with nothing to do takes none. busy holds for the whole command;
// done strobes in the cycle busy drops, and a new beat is accepted only while idle.
// The receiver cannot stall done; rst_n clears control state, slots are undefined.
module priority_task_scheduler
    import pts_pkg::*;
#(
    parameter int MAX_TASKS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_item_t    cmd_in,
    output logic        done,
    output out_item_t   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_PASS1, S_PASS2, S_PASS3, S_DONE
    } state_t;

    state_t             state_reg;
    in_item_t           item_reg;
    logic [3:0]         idle_prio_reg;
    logic [IDX_W:0]     count_reg;
    logic [IDX_W-1:0]   run_slot_reg;
    logic               run_present_reg;
    logic               started_reg;
    logic [IDX_W-1:0]   idle_slot_reg;
    logic               ok_reg;
    logic [IDX_W-1:0]   new_reg;
    logic               sw_reg;
    logic [5:0]         wait_reg;
    link_t              head_reg;
    out_item_t          result_reg;
    logic               done_reg;

    link_t              chain [MAX_TASKS+1];
    link_t              tail;
    logic               full;

    assign chain[0] = head_reg;
    assign tail     = chain[MAX_TASKS];
    assign full     = count_reg >= (IDX_W+1)'(MAX_TASKS);

    // Row of slot cells
    for (genvar g = 0; g < MAX_TASKS; g++)
    begin : g_cell
        pts_cell #(.IDX_W(IDX_W)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .my_idx   (IDX_W'(g)),
            .count    (count_reg),
            .link_in  (chain[g]),
            .link_out (chain[g+1])
        );
    end

    // APB: always ready, idle_priority at address 0
    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {28'd0, idle_prio_reg} : 32'd0;
    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_prio_reg <= '0;
        else if (psel && penable && pwrite && paddr == 1'b0)
            idle_prio_reg <= pwdata[3:0];
    end

    function automatic link_t mk_link(op_t op, logic [5:0] tgt);
        link_t l;
        l            = '0;
        l.active     = 1'b1;
        l.op         = op;
        l.tgt        = tgt;
        l.lowest     = '1;
        return l;
    endfunction

    // Sequencer: issue passes, wait for them to leave the chain, report
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            item_reg        <= '0;
            count_reg       <= '0;
            run_slot_reg    <= '0;
            run_present_reg <= 1'b0;
            started_reg     <= 1'b0;
            idle_slot_reg   <= '0;
            done_reg        <= 1'b0;
            result_reg      <= '0;
            head_reg        <= '0;
            wait_reg        <= '0;
            ok_reg          <= 1'b0;
            new_reg         <= '0;
            sw_reg          <= 1'b0;
        end
        else
        begin
            done_reg        <= 1'b0;
            head_reg.active <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        item_reg <= cmd_in;
                        ok_reg   <= 1'b0;
                        new_reg  <= '0;
                        sw_reg   <= 1'b0;
                        wait_reg <= 6'(MAX_TASKS);
                        state_reg <= S_DONE;
                        case (cmd_in.cmd)
                            CMD_CREATE, CMD_START:
                            begin
                                if (cmd_in.cmd == CMD_START)
                                    started_reg <= 1'b1;
                                if (!full)
                                begin
                                    head_reg      <= mk_link(OP_SCAN, '0);
                                    head_reg.prio <= (cmd_in.cmd == CMD_START) ?
                                        idle_prio_reg : cmd_in.prio_level;
                                    state_reg <= S_PASS1;
                                end
                                else if (cmd_in.cmd == CMD_START)
                                    idle_slot_reg <= IDX_W'(count_reg - 1'b1);
                            end
                            CMD_TICK:
                            begin
                                if (started_reg)
                                begin
                                    head_reg       <= mk_link(OP_TICK, 6'(run_slot_reg));
                                    head_reg.fresh <= run_present_reg;
                                    state_reg      <= S_PASS2;
                                end
                            end
                            CMD_DELAY, CMD_TERM:
                            begin
                                if (run_present_reg)
                                begin
                                    head_reg <= mk_link(OP_SETRUN, 6'(run_slot_reg));
                                    head_reg.tgt_status <= (cmd_in.cmd == CMD_DELAY) ?
                                        ST_DELAY : ST_TERM;
                                    head_reg.tgt_delay <= DELAY_W'(cmd_in.delay_ticks) +
                                        DELAY_W'(1);
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_PASS1:
                begin
                    // scan done: launch insert at the computed rank
                    if (tail.active)
                    begin
                        head_reg      <= mk_link(OP_INSERT, 6'(count_reg));
                        head_reg.prio <= tail.prio;
                        head_reg.pos  <= (count_reg != '0 && tail.prio > tail.lowest) ?
                            tail.pos : 8'd0;
                        ok_reg    <= 1'b1;
                        new_reg   <= IDX_W'(count_reg);
                        if (item_reg.cmd == CMD_START)
                            idle_slot_reg <= IDX_W'(count_reg);
                        count_reg <= count_reg + 1'b1;
                        wait_reg  <= 6'(MAX_TASKS);
                        state_reg <= S_DONE;
                    end
                end
                S_PASS2:
                begin
                    // countdown done: pick the top ready slot
                    if (tail.active)
                    begin
                        head_reg  <= mk_link(OP_PICK, '0);
                        state_reg <= S_PASS3;
                    end
                end
                S_PASS3:
                begin
                    if (tail.active)
                    begin
                        wait_reg  <= 6'(MAX_TASKS);
                        state_reg <= S_DONE;
                        if (tail.found || run_present_reg)
                        begin
                            head_reg <= mk_link(OP_SETRUN,
                                tail.found ? tail.best_idx : 6'(idle_slot_reg));
                            head_reg.tgt_status <= ST_RUN;
                            run_slot_reg <= tail.found ? tail.best_idx[IDX_W-1:0] :
                                idle_slot_reg;
                            run_present_reg <= 1'b1;
                            sw_reg <= 1'b1;
                        end
                    end
                end
                S_DONE:
                begin
                    // the last beat sits at the chain tail when the wait runs out
                    wait_reg <= wait_reg - 1'b1;
                    if (wait_reg == 6'd0)
                    begin
                        done_reg                 <= 1'b1;
                        result_reg.create_ok     <= ok_reg;
                        result_reg.new_task      <= SLOT_W'(new_reg);
                        result_reg.running_valid <= run_present_reg;
                        result_reg.running_task  <= run_present_reg ?
                            SLOT_W'(run_slot_reg) : '0;
                        result_reg.switched      <= sw_reg;
                        result_reg.start_fresh   <= sw_reg & tail.fresh;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // Task count never exceeds the table size
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (IDX_W+1)'(MAX_TASKS))
        else $error("task count overflow");
    // A result strobe always ends a busy period
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");
    // Running slot always refers to a filled slot
    a_run: assert property (@(posedge clk) disable iff (!rst_n)
        run_present_reg |-> ({1'b0, run_slot_reg} < count_reg))
        else $error("running slot not filled");
`endif

endmodule
